>>> rtl/tmnb_pkg.sv
// ----------------------------------------------------------------------------
// tmnb_pkg
// Shared widths, defaults and item kind codes for the toroidal neighbour board.
// ----------------------------------------------------------------------------
package tmnb_pkg;

    localparam int SIZE_X_DEF = 64;
    localparam int SIZE_Y_DEF = 64;
    localparam int NEIGHBOURS = 8;

    localparam int KIND_W  = 2;
    localparam int COORD_W = 16;
    localparam int COUNT_W = $clog2(NEIGHBOURS + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_COUNT = 2'd2
    } t_kind;

endpackage

>>> rtl/tmnb_if.sv
// ----------------------------------------------------------------------------
// tmnb_if
// Valid/ready channels carrying the board's request and result words.
// ----------------------------------------------------------------------------
interface tmnb_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [tmnb_pkg::KIND_W-1:0]          kind;
    logic signed [tmnb_pkg::COORD_W-1:0]  coord_x;
    logic signed [tmnb_pkg::COORD_W-1:0]  coord_y;
    logic                                 write_value;

    modport source (output valid, kind, coord_x, coord_y, write_value, input ready);
    modport sink   (input valid, kind, coord_x, coord_y, write_value, output ready);
endinterface

interface tmnb_out_if;
    logic                         valid;
    logic                         ready;
    logic                         cell_value;
    logic [tmnb_pkg::COUNT_W-1:0] neighbour_count;

    modport source (output valid, cell_value, neighbour_count, input ready);
    modport sink   (input valid, cell_value, neighbour_count, output ready);
endinterface

>>> rtl/toroidal_moore_neighbour_board.sv
// ----------------------------------------------------------------------------
// toroidal_moore_neighbour_board: one-bit cell board on a torus
// One word at a time: the next is taken only after the last result is loaded
// into the output register, which a stalled result channel can hold up. The
// single row-wide memory port sets the pace: three row reads per neighbour count.
// Reset: clearing pass over the rows; no word taken until done.
// ----------------------------------------------------------------------------
module toroidal_moore_neighbour_board #(
    parameter int SIZE_X = tmnb_pkg::SIZE_X_DEF,  // 3 .. 64 columns
    parameter int SIZE_Y = tmnb_pkg::SIZE_Y_DEF   // 3 .. 4096 rows
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmnb_in_if.sink       i_in,
    tmnb_out_if.source    o_out
);

    localparam int XW = $clog2(SIZE_X);
    localparam int YW = $clog2(SIZE_Y);
    localparam int CW = tmnb_pkg::COORD_W;
    localparam int CN = tmnb_pkg::COUNT_W;

    // Coordinates are biased by half the signed range to make them unsigned;
    // the bias residue is taken back off after the reduction.
    localparam int BIAS  = 2 ** (CW - 1);
    localparam int OFF_X = BIAS % SIZE_X;
    localparam int OFF_Y = BIAS % SIZE_Y;

    // Reciprocals for the modulo: q = (u * floor(2^32 / N)) >> 32 is at most
    // one short of u / N, so the remainder needs a single correction.
    localparam logic [31:0] RECIP_X = 32'((64'd1 << 32) / SIZE_X);
    localparam logic [31:0] RECIP_Y = 32'((64'd1 << 32) / SIZE_Y);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_MUL   = 10'b00_0000_0100,
        ST_REM   = 10'b00_0000_1000,
        ST_FIX   = 10'b00_0001_0000,
        ST_ACC0  = 10'b00_0010_0000,
        ST_ACC1  = 10'b00_0100_0000,
        ST_ACC2  = 10'b00_1000_0000,
        ST_ACC3  = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } t_state;

    t_state                  r_state, n_state;

    // Accepted word
    logic [tmnb_pkg::KIND_W-1:0] r_kind;
    logic [CW-1:0]           r_ux, r_uy;
    logic                    r_wv;

    // Coordinate reduction pipeline
    logic [CW-1:0]           r_qx, r_qy;
    logic [XW:0]             r_rx;
    logic [YW:0]             r_ry;
    logic [XW-1:0]           r_x;
    logic [YW-1:0]           r_y;

    // Result build-up
    logic                    r_cell;
    logic [CN-1:0]           r_cnt;

    // Clearing pass
    logic [YW-1:0]           r_clr;

    // Row memory
    logic [SIZE_X-1:0]       r_mem [SIZE_Y];
    logic [SIZE_X-1:0]       r_rdata;
    logic                    mem_we;
    logic [YW-1:0]           mem_addr;
    logic [SIZE_X-1:0]       mem_wdata;

    // Output register
    logic                    r_out_valid;
    logic                    r_out_cell;
    logic [CN-1:0]           r_out_count;

    logic                    in_take;
    logic                    out_free;
    logic                    is_count;
    logic [47:0]             prod_x, prod_y;
    logic [31:0]             rem_x, rem_y;
    logic [XW:0]             tx;
    logic [YW:0]             ty;
    logic [XW-1:0]           x_l, x_r;
    logic [YW-1:0]           y_up, y_dn;
    logic [SIZE_X-1:0]       row_upd;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_take    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign is_count   = (r_kind == tmnb_pkg::KIND_COUNT);

    assign o_out.valid           = r_out_valid;
    assign o_out.cell_value      = r_out_cell;
    assign o_out.neighbour_count = r_out_count;

    // Reduction arithmetic: one multiply per stage, correction in the last
    assign prod_x = 48'(r_ux) * 48'(RECIP_X);
    assign prod_y = 48'(r_uy) * 48'(RECIP_Y);
    assign rem_x  = 32'(r_ux) - 32'(r_qx) * 32'(SIZE_X);
    assign rem_y  = 32'(r_uy) - 32'(r_qy) * 32'(SIZE_Y);
    assign tx     = (r_rx >= (XW+1)'(SIZE_X)) ? r_rx - (XW+1)'(SIZE_X) : r_rx;
    assign ty     = (r_ry >= (YW+1)'(SIZE_Y)) ? r_ry - (YW+1)'(SIZE_Y) : r_ry;

    // Neighbour columns and rows, wrapped around the torus
    assign x_l  = (r_x == '0) ? XW'(SIZE_X - 1) : r_x - XW'(1);
    assign x_r  = (r_x == XW'(SIZE_X - 1)) ? '0 : r_x + XW'(1);
    assign y_up = (r_y == '0) ? YW'(SIZE_Y - 1) : r_y - YW'(1);
    assign y_dn = (r_y == YW'(SIZE_Y - 1)) ? '0 : r_y + YW'(1);

    always_comb begin
        row_upd       = r_rdata;
        row_upd[r_x]  = r_wv;
    end

    // Memory port: one access per cycle, address chosen by the sequencer
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_y;
        mem_wdata = row_upd;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
            end
            ST_ACC0: begin
                mem_addr = is_count ? y_up : r_y;
            end
            ST_ACC1: begin
                // write back the modified row, or fetch the own row for a count
                mem_we   = (r_kind == tmnb_pkg::KIND_WRITE);
                mem_addr = r_y;
            end
            ST_ACC2: begin
                mem_addr = y_dn;
            end
            ST_IDLE, ST_MUL, ST_REM, ST_FIX, ST_ACC3, ST_OUT: begin
                mem_addr = r_y;
            end
            default: begin
                mem_addr = r_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == YW'(SIZE_Y - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (in_take) n_state = ST_MUL;
            ST_MUL:   n_state = ST_REM;
            ST_REM:   n_state = ST_FIX;
            ST_FIX:   n_state = ST_ACC0;
            ST_ACC0:  n_state = ST_ACC1;
            ST_ACC1:  n_state = is_count ? ST_ACC2 : ST_OUT;
            ST_ACC2:  n_state = ST_ACC3;
            ST_ACC3:  n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + YW'(1);
            end
            // Hold the result until taken; reload only when the slot frees
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_in.kind;
            r_ux   <= {~i_in.coord_x[CW-1], i_in.coord_x[CW-2:0]};
            r_uy   <= {~i_in.coord_y[CW-1], i_in.coord_y[CW-2:0]};
            r_wv   <= i_in.write_value;
            r_cnt  <= '0;
        end
        if (r_state == ST_MUL) begin
            r_qx <= prod_x[47:32];
            r_qy <= prod_y[47:32];
        end
        if (r_state == ST_REM) begin
            r_rx <= rem_x[XW:0];
            r_ry <= rem_y[YW:0];
        end
        if (r_state == ST_FIX) begin
            // drop the bias residue, wrapping back into range
            r_x <= (tx >= (XW+1)'(OFF_X)) ? XW'(tx - (XW+1)'(OFF_X))
                                          : XW'(tx + (XW+1)'(SIZE_X - OFF_X));
            r_y <= (ty >= (YW+1)'(OFF_Y)) ? YW'(ty - (YW+1)'(OFF_Y))
                                          : YW'(ty + (YW+1)'(SIZE_Y - OFF_Y));
        end
        if (r_state == ST_ACC1) begin
            if (is_count) begin
                // row above: three neighbours
                r_cnt <= CN'(r_rdata[x_l]) + CN'(r_rdata[r_x]) + CN'(r_rdata[x_r]);
            end else if (r_kind == tmnb_pkg::KIND_WRITE) begin
                r_cell <= r_wv;
            end else begin
                r_cell <= r_rdata[r_x];
            end
        end
        if (r_state == ST_ACC2) begin
            // own row: two side neighbours and the cell itself
            r_cnt  <= r_cnt + CN'(r_rdata[x_l]) + CN'(r_rdata[x_r]);
            r_cell <= r_rdata[r_x];
        end
        if (r_state == ST_ACC3) begin
            // row below: three neighbours
            r_cnt <= r_cnt + CN'(r_rdata[x_l]) + CN'(r_rdata[r_x]) + CN'(r_rdata[x_r]);
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_cell  <= r_cell;
            r_out_count <= r_cnt;
        end
    end

endmodule

>>> verif/tmnb_board_checker.sv
// ----------------------------------------------------------------------------
// tmnb_board_checker
// Watches the request and result channels of the toroidal neighbour board,
// keeps its own copy of the board, predicts each result word and compares.
// ----------------------------------------------------------------------------
module tmnb_board_checker #(
    parameter int SIZE_X = tmnb_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = tmnb_pkg::SIZE_Y_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tmnb_in_if    i_req,
    tmnb_out_if   i_res,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KW  = tmnb_pkg::KIND_W;
    localparam int CNW = tmnb_pkg::COUNT_W;

    typedef struct packed {
        logic           cell_value;
        logic [CNW-1:0] neighbour_count;
    } t_board_result;

    logic [SIZE_X-1:0] board_rows [SIZE_Y];
    t_board_result     result_fifo[$];
    int                fails;

    function automatic int wrap_to(input int v, input int size);
        int r;
        r = v % size;
        if (r < 0) begin
            r += size;
        end
        return r;
    endfunction

    // Apply one request word to the board copy and return its result word.
    function automatic t_board_result board_apply(input logic [KW-1:0] kind,
                                                  input int sx, input int sy,
                                                  input logic wv);
        t_board_result res;
        int            x;
        int            y;
        int            live;
        x    = wrap_to(sx, SIZE_X);
        y    = wrap_to(sy, SIZE_Y);
        live = 0;
        if (kind == tmnb_pkg::KIND_WRITE) begin
            board_rows[y][x] = wv;
        end else if (kind == tmnb_pkg::KIND_COUNT) begin
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    if (dx != 0 || dy != 0) begin
                        live += board_rows[wrap_to(y + dy, SIZE_Y)][wrap_to(x + dx, SIZE_X)];
                    end
                end
            end
        end
        res.cell_value      = board_rows[y][x];
        res.neighbour_count = live[CNW-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_board_result want;
        if (!i_rst_n) begin
            for (int r = 0; r < SIZE_Y; r++) begin
                board_rows[r] = '0;
            end
            result_fifo.delete();
            fails = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                result_fifo.push_back(board_apply(i_req.kind, int'(i_req.coord_x),
                                                  int'(i_req.coord_y), i_req.write_value));
            end
            if (i_res.valid && i_res.ready) begin
                if (result_fifo.size() == 0) begin
                    $error("result word with nothing expected: cell_value %0d neighbour_count %0d",
                           i_res.cell_value, i_res.neighbour_count);
                    fails++;
                end else begin
                    want = result_fifo.pop_front();
                    if (i_res.cell_value !== want.cell_value) begin
                        $error("cell_value: expected %0d, got %0d",
                               want.cell_value, i_res.cell_value);
                        fails++;
                    end
                    if (i_res.neighbour_count !== want.neighbour_count) begin
                        $error("neighbour_count: expected %0d, got %0d",
                               want.neighbour_count, i_res.neighbour_count);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_fifo.size();
    end

endmodule

>>> verif/toroidal_moore_neighbour_board_tb.sv
// ----------------------------------------------------------------------------
// toroidal_moore_neighbour_board_tb
// Drives write, read and neighbour-count words into the board with random
// gaps on both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module toroidal_moore_neighbour_board_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOARD_X = tmnb_pkg::SIZE_X_DEF;
    localparam int BOARD_Y = tmnb_pkg::SIZE_Y_DEF;
    localparam int KW      = tmnb_pkg::KIND_W;
    localparam int CW      = tmnb_pkg::COORD_W;

    // The spare kind code is not in the package enum; the block treats it as a read.
    localparam logic [KW-1:0] KIND_SPARE = 2'd3;

    localparam int RANDOM_WORDS = 1750;
    // Well above the slowest legal run, so only a hang trips the limit.
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;
    int   words_sent;
    int   cycle_count;
    int   fail_count;
    int   pending_words;

    tmnb_in_if  req_ch ();
    tmnb_out_if res_ch ();

    toroidal_moore_neighbour_board #(
        .SIZE_X (BOARD_X),
        .SIZE_Y (BOARD_Y)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    tmnb_board_checker #(
        .SIZE_X (BOARD_X),
        .SIZE_Y (BOARD_Y)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // 20 ns clock.
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: give up if the run hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("toroidal_moore_neighbour_board_tb: done, errors");
            $finish;
        end
    end

    // Result side: stall at random about 8 percent of the time, but hold ready high through
    // a calm stretch so back-to-back words drain at full rate.
    always @(negedge clk) begin
        res_ch.ready <= (words_sent >= 800 && words_sent < 1100) ||
                        ($urandom_range(0, 99) >= 8);
    end

    // Present one request word at the falling edge and hold it until the
    // block takes it. Insert the odd idle cycle first, except in a calm stretch of its own.
    task automatic send_word(input logic [KW-1:0] kind,
                             input logic signed [CW-1:0] cx,
                             input logic signed [CW-1:0] cy,
                             input logic wv);
        @(negedge clk);
        while (!(words_sent >= 700 && words_sent < 1000) && $urandom_range(0, 99) < 8) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.coord_x     <= cx;
        req_ch.coord_y     <= cy;
        req_ch.write_value <= wv;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // Turn a wrapped position into a 16-bit coordinate: mostly the plain or
    // one-lap-negative form, sometimes a random lap, so the full range is hit.
    function automatic logic signed [CW-1:0] encode_coord(input int pos, input int size);
        int lap_lo;
        int lap_hi;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return CW'(pos);
        end else if (pick < 70) begin
            return CW'(pos - size);
        end
        lap_lo = -((32768 + pos) / size);
        lap_hi = (32767 - pos) / size;
        return CW'(pos + size * (lap_lo + int'($urandom_range(0, lap_hi - lap_lo))));
    endfunction

    initial begin
        int                   hot_x;
        int                   hot_y;
        int                   pick;
        logic [KW-1:0]        kind;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;

        // Known values on every input from time zero.
        rst_n              = 1'b0;
        words_sent         = 0;
        cycle_count        = 0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = tmnb_pkg::KIND_READ;
        req_ch.coord_x     = '0;
        req_ch.coord_y     = '0;
        req_ch.write_value = 1'b0;
        res_ch.ready       = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // The clearing pass holds ready low; the first handshake simply waits it out.

        // ---- Directed words ----
        // Count on the cleared board, then ring the corner cell with live
        // neighbours, five of which sit across a wrapped edge.
        send_word(tmnb_pkg::KIND_COUNT, 16'sd0, 16'sd0, 1'b1);
        send_word(tmnb_pkg::KIND_WRITE, -16'sd1, -16'sd1, 1'b1);
        send_word(tmnb_pkg::KIND_WRITE, CW'(BOARD_X),
                  16'sd32767 - CW'(32767 % BOARD_Y) - 16'sd1, 1'b1);
        send_word(tmnb_pkg::KIND_WRITE, 16'sd1, -16'sd1, 1'b1);
        send_word(tmnb_pkg::KIND_WRITE, CW'(BOARD_X - 1), 16'sd0, 1'b1);
        send_word(tmnb_pkg::KIND_WRITE, 16'sd1, CW'(-BOARD_Y), 1'b1);
        send_word(tmnb_pkg::KIND_WRITE, -16'sd1, 16'sd1, 1'b1);
        send_word(tmnb_pkg::KIND_WRITE, -16'sd32768, 16'sd1, 1'b1);
        send_word(tmnb_pkg::KIND_WRITE, CW'(1 - BOARD_X), CW'(BOARD_Y + 1), 1'b1);
        // Full neighbourhood around a dead centre.
        send_word(tmnb_pkg::KIND_COUNT, 16'sd0, 16'sd0, 1'b0);
        // Bring the centre alive through the most negative coordinates.
        send_word(tmnb_pkg::KIND_WRITE, -16'sd32768, -16'sd32768, 1'b1);
        send_word(tmnb_pkg::KIND_COUNT, CW'(BOARD_X), CW'(-BOARD_Y), 1'b0);
        // Spare kind reads and ignores the write value.
        send_word(KIND_SPARE, 16'sd0, 16'sd0, 1'b0);
        send_word(KIND_SPARE, -16'sd1, -16'sd1, 1'b1);
        // Kill the far corner through the most positive coordinates.
        send_word(tmnb_pkg::KIND_WRITE, 16'sd32767, 16'sd32767, 1'b0);
        send_word(tmnb_pkg::KIND_READ, 16'sd32767, 16'sd32767, 1'b1);
        send_word(tmnb_pkg::KIND_COUNT, 16'sd0, 16'sd0, 1'b1);
        send_word(tmnb_pkg::KIND_COUNT, -16'sd1, -16'sd1, 1'b0);
        send_word(tmnb_pkg::KIND_COUNT, 16'sd1, 16'sd1, 1'b0);
        send_word(tmnb_pkg::KIND_COUNT, 16'sd32767, -16'sd32768, 1'b0);
        send_word(tmnb_pkg::KIND_READ, 16'sd0, 16'sd0, 1'b0);
        send_word(tmnb_pkg::KIND_WRITE, 16'sd0, 16'sd0, 1'b0);
        send_word(tmnb_pkg::KIND_COUNT, 16'sd0, -16'sd1, 1'b0);

        // ---- Random words ----
        // Work around a hot spot, moved now and then and often on an edge, so
        // the board gets dense locally and counts spread over the whole range.
        hot_x = 0;
        hot_y = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 150 == 0) begin
                hot_x = ($urandom_range(0, 1) != 0) ? ($urandom_range(0, 1) ? BOARD_X - 1 : 0)
                                                    : int'($urandom_range(0, BOARD_X - 1));
                hot_y = ($urandom_range(0, 1) != 0) ? ($urandom_range(0, 1) ? BOARD_Y - 1 : 0)
                                                    : int'($urandom_range(0, BOARD_Y - 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                kind = tmnb_pkg::KIND_WRITE;
            end else if (pick < 55) begin
                kind = tmnb_pkg::KIND_READ;
            end else if (pick < 95) begin
                kind = tmnb_pkg::KIND_COUNT;
            end else begin
                kind = KIND_SPARE;
            end
            if ($urandom_range(0, 99) < 10) begin
                // Anywhere at all: every coordinate bit toggles.
                cx = CW'($urandom);
                cy = CW'($urandom);
            end else begin
                cx = encode_coord(((hot_x + int'($urandom_range(0, 4)) - 2) % BOARD_X + BOARD_X)
                                  % BOARD_X, BOARD_X);
                cy = encode_coord(((hot_y + int'($urandom_range(0, 4)) - 2) % BOARD_Y + BOARD_Y)
                                  % BOARD_Y, BOARD_Y);
            end
            // Lean writes towards live cells so neighbourhoods fill up.
            send_word(kind, cx, cy, $urandom_range(0, 99) < 60);
        end

        // Drop valid and drain.
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_words != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("toroidal_moore_neighbour_board_tb: done, clean");
        end else begin
            $display("toroidal_moore_neighbour_board_tb: done, errors");
        end
        $finish;
    end

endmodule
